@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the gated recurrent cell.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ sv/grc_pkg.sv @@
// Package for the gated recurrent cell: widths and the sigmoid knot table.
// No dependencies.
package grc_pkg;
    localparam int DATA_W_DEF = 16;
    localparam int FRAC_W_DEF = 12;
    localparam int KNOT_BITS  = 24;
    localparam int NUM_KNOTS  = 17;

    // sigmoid at integers -8..8, Q.24, rounded
    function automatic logic [KNOT_BITS-1:0] knot(input logic [4:0] k);
        logic [KNOT_BITS-1:0] r;
        begin
            case (k)
                5'd0:  r = 24'd5626;
                5'd1:  r = 24'd15285;
                5'd2:  r = 24'd41484;
                5'd3:  r = 24'd112287;
                5'd4:  r = 24'd301759;
                5'd5:  r = 24'd795674;
                5'd6:  r = 24'd1999893;
                5'd7:  r = 24'd4512088;
                5'd8:  r = 24'd8388608;
                5'd9:  r = 24'd12265128;
                5'd10: r = 24'd14777323;
                5'd11: r = 24'd15981542;
                5'd12: r = 24'd16475457;
                5'd13: r = 24'd16664929;
                5'd14: r = 24'd16735732;
                5'd15: r = 24'd16761931;
                default: r = 24'd16771590;
            endcase
            return r;
        end
    endfunction
endpackage

@@ sv/gated_rnn_cell_forward.sv @@
// Top level of the gated recurrent cell pointwise update.
// Depends on grc_pkg, grc_sigmoid and assert_macros.svh.
//
// Usage: one element per beat. The slave channel (i_s_axis_*) carries the nine
// Q4.12 operands packed in tdata; the master channel (o_m_axis_*) carries the
// five results. There is no configuration and no state between elements.
// Pipeline: 12 register stages. An accepted beat passes through all of them
// in order and is loaded into the output register at stage 12, where the
// master side shows it until the receiver takes it. Throughput is one beat
// per cycle while the receiver does not stall, set by the fully pipelined
// datapath: three sigmoid units, each two stages, and one multiplier stage
// per product.
// Stalls: the whole pipeline advances on a single enable, which is high when
// the output register is empty or taken. o_s_axis_tready follows the same
// enable, so a stalled receiver freezes every stage and nothing is lost.
// Reset (i_rst_n low, synchronous) clears all valid bits and holds tready low;
// payload is not reset.
// Stages: 1 sums, 2-3 sigmoids of gate and 2v, 4 cand and blend products,
// 5 blend scale, 6 output gate sum, 7-8 sigmoid(g), 9 silu product,
// 10 silu scale, 11 output product, 12 output scale into the output register.
`include "assert_macros.svh"
module gated_rnn_cell_forward import grc_pkg::*; #(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int FRAC_BITS  = FRAC_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // prev_state, input_value, cand_in_proj, cand_rec_proj, gate_in_proj,
    // gate_rec_proj, cand_bias, gate_bias, out_gate_bias (low bits first)
    input  logic [((9 * DATA_WIDTH) + 7) / 8 * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // new_state, gated_output, cand_preact, update_gate, out_silu (low first)
    output logic [((4 * DATA_WIDTH + FRAC_BITS + 1) + 7) / 8 * 8 - 1:0] o_m_axis_tdata
);
    localparam int DW   = DATA_WIDTH;
    localparam int FW   = FRAC_BITS;
    localparam int TDO_W = ((4 * DW + FW + 1) + 7) / 8 * 8;
    localparam int NST  = 12;
    localparam int PW   = 2 * DW + 4;
    localparam logic signed [DW+3:0] SMAX = (DW+4)'((1 << (DW - 1)) - 1);
    localparam logic signed [DW+3:0] SMIN = -SMAX - (DW+4)'(1);
    localparam logic signed [PW-1:0] PMAX = PW'(SMAX);
    localparam logic signed [PW-1:0] PMIN = PW'(SMIN);
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FW - 1);

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW+3:0] v);
        logic signed [DW-1:0] r;
        begin
            if (v > SMAX)      r = SMAX[DW-1:0];
            else if (v < SMIN) r = SMIN[DW-1:0];
            else               r = v[DW-1:0];
            return r;
        end
    endfunction

    function automatic logic signed [DW-1:0] scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic signed [DW-1:0] r;
        begin
            s = (p + HALF) >>> FW;
            if (s > PMAX)      r = PMAX[DW-1:0];
            else if (s < PMIN) r = PMIN[DW-1:0];
            else               r = s[DW-1:0];
            return r;
        end
    endfunction

    logic              en;
    logic [NST-1:0]    r_vld;
    logic signed [DW-1:0] in_f [9];

    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;
    assign o_m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
    end

    always_comb begin
        for (int k = 0; k < 9; k++) in_f[k] = i_s_axis_tdata[k*DW +: DW];
    end

    // stage 1: saturated three-term sums
    logic signed [DW-1:0] r1_h, r1_x, r1_ob, r1_v, r1_gs;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h  <= in_f[0];
            r1_x  <= in_f[1];
            r1_ob <= in_f[8];
            r1_v  <= sat_sum((DW+4)'(in_f[2]) + (DW+4)'(in_f[3]) + (DW+4)'(in_f[6]));
            r1_gs <= sat_sum((DW+4)'(in_f[4]) + (DW+4)'(in_f[5]) + (DW+4)'(in_f[7]));
        end
    end

    // stages 2-3: sigmoid of gate sum and of 2v
    logic [FW:0] u_s, c_s;
    grc_sigmoid #(.IN_W(DW + 1), .FRAC_W(FW)) u_sig_gate (
        .i_clk(i_clk), .i_en(en), .i_x((DW+1)'(r1_gs)), .o_y(u_s));
    grc_sigmoid #(.IN_W(DW + 1), .FRAC_W(FW)) u_sig_cand (
        .i_clk(i_clk), .i_en(en), .i_x({r1_v, 1'b0}), .o_y(c_s));

    logic signed [DW-1:0] r2_h, r2_x, r2_ob, r2_v, r3_h, r3_x, r3_ob, r3_v;
    logic [FW:0] r3_u;
    logic signed [FW+2:0] r3_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_h <= r1_h;  r2_x <= r1_x;  r2_ob <= r1_ob;  r2_v <= r1_v;
            r3_h <= r2_h;  r3_x <= r2_x;  r3_ob <= r2_ob;  r3_v <= r2_v;
            r3_u <= u_s;
            r3_c <= (FW+3)'({c_s, 1'b0}) - ((FW+3)'(1) <<< FW);
        end
    end

    // stage 4: blend products
    logic signed [PW-1:0] r4_pa, r4_pb;
    logic signed [DW-1:0] r4_x, r4_ob, r4_v;
    logic [FW:0]          r4_u;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_pa <= PW'((FW+3)'(1 << FW) - (FW+3)'(r3_u)) * PW'(r3_h);
            r4_pb <= PW'((FW+3)'(r3_u)) * PW'(r3_c);
            r4_x  <= r3_x;  r4_ob <= r3_ob;  r4_v <= r3_v;  r4_u <= r3_u;
        end
    end

    // stage 5: scale blend; stage 6: output gate sum
    logic signed [DW-1:0] r5_h, r5_x, r5_ob, r5_v, r6_h, r6_g, r6_v;
    logic [FW:0] r5_u, r6_u;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_h <= scale(r4_pa + r4_pb);
            r5_x <= r4_x;  r5_ob <= r4_ob;  r5_v <= r4_v;  r5_u <= r4_u;
            r6_h <= r5_h;  r6_v <= r5_v;  r6_u <= r5_u;
            r6_g <= sat_sum((DW+4)'(r5_h) + (DW+4)'(r5_x) + (DW+4)'(r5_ob));
        end
    end

    // stages 7-8: sigmoid(g)
    logic [FW:0] g_s;
    grc_sigmoid #(.IN_W(DW + 1), .FRAC_W(FW)) u_sig_out (
        .i_clk(i_clk), .i_en(en), .i_x((DW+1)'(r6_g)), .o_y(g_s));

    logic signed [DW-1:0] r7_h, r7_g, r7_v, r8_h, r8_g, r8_v;
    logic [FW:0] r7_u, r8_u, r8_s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_h <= r6_h;  r7_g <= r6_g;  r7_v <= r6_v;  r7_u <= r6_u;
            r8_h <= r7_h;  r8_g <= r7_g;  r8_v <= r7_v;  r8_u <= r7_u;
            r8_s <= g_s;
        end
    end

    // stage 9: silu product; stage 10: scale; stage 11: output product
    logic signed [PW-1:0] r9_p, r11_p;
    logic signed [DW-1:0] r9_h, r9_v, r10_h, r10_v, r10_si, r11_h, r11_v, r11_si;
    logic [FW:0] r9_u, r10_u, r11_u;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_p   <= PW'(r8_g) * PW'((FW+2)'(r8_s));
            r9_h   <= r8_h;  r9_v <= r8_v;  r9_u <= r8_u;
            r10_si <= scale(r9_p);
            r10_h  <= r9_h;  r10_v <= r9_v;  r10_u <= r9_u;
            r11_p  <= PW'(r10_h) * PW'(r10_si);
            r11_h  <= r10_h;  r11_v <= r10_v;  r11_u <= r10_u;  r11_si <= r10_si;
        end
    end

    // stage 12: output register
    logic [TDO_W-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= TDO_W'({r11_si, r11_u, r11_v, scale(r11_p), r11_h});
        end
    end
    assign o_m_axis_tdata = r_out;

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `ASSERT_IMP(a_ready_en, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    `ASSERT_IMP(a_gate_range, i_clk, i_rst_n, o_m_axis_tvalid, r_out[3*DW +: FW+1] <= (FW+1)'(1 << FW))
endmodule

@@ sv/grc_sigmoid.sv @@
// Piecewise-linear sigmoid: registered knot lookup, then interpolation.
// Depends on grc_pkg.
module grc_sigmoid import grc_pkg::*; #(
    parameter int IN_W   = DATA_W_DEF + 1,
    parameter int FRAC_W = FRAC_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [IN_W-1:0]   i_x,
    output logic        [FRAC_W:0]   o_y
);
    localparam int SH  = KNOT_BITS - FRAC_W;
    localparam int XW  = IN_W + 2;
    localparam logic signed [XW-1:0] LIM = XW'(8) <<< FRAC_W;

    logic signed [XW-1:0]  x_ext, u;
    logic [KNOT_BITS-1:0]  n_base, n_d, r_base, r_d;
    logic [FRAC_W-1:0]     n_frac, r_frac;
    logic [4:0]            seg;
    logic [KNOT_BITS+FRAC_W-1:0] prod;
    logic [KNOT_BITS:0]    y, yr;

    always_comb begin
        x_ext  = XW'(i_x);
        u      = x_ext + LIM;
        seg    = u[FRAC_W +: 5];
        n_frac = u[FRAC_W-1:0];
        if (x_ext < -LIM) begin
            n_base = knot(5'd0);
            n_d    = '0;
        end else if (x_ext >= LIM) begin
            n_base = knot(5'd16);
            n_d    = '0;
        end else begin
            n_base = knot(seg);
            n_d    = knot(seg + 5'd1) - knot(seg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= n_base;
            r_d    <= n_d;
            r_frac <= n_frac;
        end
    end

    always_comb begin
        prod = (KNOT_BITS+FRAC_W)'(r_d) * (KNOT_BITS+FRAC_W)'(r_frac);
        y    = (KNOT_BITS+1)'(r_base) + (KNOT_BITS+1)'(prod >> FRAC_W);
        if (SH > 0) yr = (y + (KNOT_BITS+1)'(1 << (SH - 1))) >> SH;
        else        yr = y;
        o_y = yr[FRAC_W:0];
    end
endmodule
